>>> src/shp_pkg.sv
// Shared types and constants for the 3x3 RGB sharpening stream block.
// Used by the top level, the kernel and the port checker.
`default_nettype none

package shp_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 8;
  localparam int MIN_DIM        = 3;
  localparam int SAT_MAX        = 255;

  localparam int CH_W         = 8;
  localparam int NUM_CH       = 3;
  localparam int PIX_W        = NUM_CH * CH_W;
  localparam int TDATA_W      = PIX_W;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int COEF_W       = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int WIN_TAPS   = 9;
  localparam int CENTER_TAP = 4;

  localparam logic signed [COEF_W-1:0] CENTER_RESET   = 16'sd1280;
  localparam logic signed [COEF_W-1:0] NEIGHBOR_RESET = -16'sd128;
  localparam int WIDTH_RESET  = 1280;
  localparam int HEIGHT_RESET = 960;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER   = 2'd0,
    REG_NEIGHBOR = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] center;
    logic signed [COEF_W-1:0] neighbor;
  } coef_t;

endpackage

`default_nettype wire

>>> src/sharpen_3x3_rgb_stream.sv
// Top level of the 3x3 RGB sharpening stream block.
// Depends on shp_pkg, shp_line_ram and shp_kernel.
//
// Takes one transaction and gives one result per clock while m_tready is
// high. A pixel leaves image_width + 1 transactions after it enters; its
// result is registered onto m_* when the transaction releasing it steps.
// Border pixels pass through, interior pixels are sharpened with the Q8.8
// center and neighbor taps. After the last pixel of a frame, image_width + 1
// pixels stay pending; drain transactions (tuser = 1) or pixels of the next
// frame push them out. Two 2048 x 24 line stores, each with one write and
// two registered reads per cycle, keep that pace; they are not cleared at
// reset. Writing image_width or image_height restarts the frame position
// and drops pending pixels; write configuration only while the block is idle.
`default_nettype none

module sharpen_3x3_rgb_stream import shp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  input  logic                  s_tuser,   // opcode: 1 = drain
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out
  output logic                  m_tlast,   // last_of_frame
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  function automatic col_t clamp_width(input logic [WIDTH_REG_W-1:0] v);
    col_t r;
    if (v < WIDTH_REG_W'(MIN_DIM)) begin
      r = COL_W'(MIN_DIM - 1);
    end else if (v > WIDTH_REG_W'(MAX_WIDTH)) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(v - WIDTH_REG_W'(1));
    end
    return r;
  endfunction

  function automatic row_t clamp_height(input logic [HEIGHT_REG_W-1:0] v);
    row_t r;
    if (v < HEIGHT_REG_W'(MIN_DIM)) begin
      r = ROW_W'(MIN_DIM - 1);
    end else if (v > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      r = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      r = ROW_W'(v - HEIGHT_REG_W'(1));
    end
    return r;
  endfunction

  // configuration
  coef_t coef;
  col_t  width_m1;
  row_t  height_m1;

  // frame positions
  row_t in_row, in_row_next, out_row, out_row_next;
  col_t in_col, in_col_next, out_col, out_col_next;

  // input register
  logic p_valid;
  logic p_drain;
  pix_t p_pix;

  pix_t win    [WIN_TAPS];
  pix_t win_sh [WIN_TAPS];

  pix_t up_a, up_b, low_a, low_b;
  pix_t filt, tail_pix, emit_pix;

  logic out_free, step, in_acc, cfg_pos_clr;
  logic early, pending, tail, do_shift, do_emit, use_lower, border, last;

  assign out_free = !m_tvalid || m_tready;
  assign step     = p_valid && out_free;
  assign s_tready = !p_valid || out_free;
  assign in_acc   = s_tvalid && s_tready;

  assign cfg_pos_clr = cfg_wr_en &&
                       (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // step decisions
  assign early     = (in_row == '0) || (in_row == ROW_W'(1) && in_col == '0);
  assign pending   = (out_row != '0) || (out_col != '0);
  assign tail      = early && pending;
  assign do_shift  = step && !p_drain;
  assign do_emit   = step && (p_drain ? tail : (tail || !early));
  // last row of the previous frame: still in the lower store until shifted up
  assign use_lower = (out_row == height_m1) && (in_row == '0) && (out_col >= in_col);
  assign tail_pix  = use_lower ? low_b : up_b;
  assign border    = (out_row == '0) || (out_row >= height_m1) ||
                     (out_col == '0) || (out_col >= width_m1);
  assign last      = (out_row == height_m1) && (out_col == width_m1);

  always_comb begin
    win_sh[0] = win[1];
    win_sh[1] = win[2];
    win_sh[2] = up_a;
    win_sh[3] = win[4];
    win_sh[4] = win[5];
    win_sh[5] = low_a;
    win_sh[6] = win[7];
    win_sh[7] = win[8];
    win_sh[8] = p_pix;
  end

  shp_kernel u_kernel (
    .win    (win_sh),
    .coef   (coef),
    .result (filt)
  );

  // start of a row and border pixels both take the old middle-right tap
  always_comb begin
    if (tail) begin
      emit_pix = tail_pix;
    end else if (in_col == '0 || border) begin
      emit_pix = win[5];
    end else begin
      emit_pix = filt;
    end
  end

  // position update; read addresses follow the next position
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (rst || cfg_pos_clr) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end else begin
      if (do_shift) begin
        if (in_col >= width_m1) begin
          in_col_next = '0;
          in_row_next = (in_row >= height_m1) ? '0 : in_row + ROW_W'(1);
        end else begin
          in_col_next = in_col + COL_W'(1);
        end
      end
      if (do_emit) begin
        if (out_col >= width_m1) begin
          out_col_next = '0;
          out_row_next = (out_row >= height_m1) ? '0 : out_row + ROW_W'(1);
        end else begin
          out_col_next = out_col + COL_W'(1);
        end
      end
    end
  end

  shp_line_ram #(.ADDR_W(COL_W), .DATA_W(PIX_W)) u_upper (
    .clk     (clk),
    .we      (do_shift),
    .waddr   (in_col),
    .wdata   (low_a),
    .raddr_a (in_col_next),
    .rdata_a (up_a),
    .raddr_b (out_col_next),
    .rdata_b (up_b)
  );

  shp_line_ram #(.ADDR_W(COL_W), .DATA_W(PIX_W)) u_lower (
    .clk     (clk),
    .we      (do_shift),
    .waddr   (in_col),
    .wdata   (p_pix),
    .raddr_a (in_col_next),
    .rdata_a (low_a),
    .raddr_b (out_col_next),
    .rdata_b (low_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.center   <= CENTER_RESET;
      coef.neighbor <= NEIGHBOR_RESET;
      width_m1      <= COL_W'(WIDTH_RESET - 1);
      height_m1     <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER:   coef.center   <= $signed(cfg_data[COEF_W-1:0]);
        REG_NEIGHBOR: coef.neighbor <= $signed(cfg_data[COEF_W-1:0]);
        REG_WIDTH:    width_m1      <= clamp_width(cfg_data[WIDTH_REG_W-1:0]);
        REG_HEIGHT:   height_m1     <= clamp_height(cfg_data[HEIGHT_REG_W-1:0]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    in_row  <= in_row_next;
    in_col  <= in_col_next;
    out_row <= out_row_next;
    out_col <= out_col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_tready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_drain <= s_tuser;
      p_pix   <= {s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W], s_tdata[PIX_W-1:2*CH_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        win[k] <= '0;
      end
    end else if (do_shift) begin
      win <= win_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= do_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      m_tdata <= {emit_pix[CH_W-1:0], emit_pix[2*CH_W-1:CH_W], emit_pix[PIX_W-1:2*CH_W]};
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

>>> src/shp_line_ram.sv
// Line store: one write port, two registered read ports, write-first on a hit.
// Generic; widths come from the instantiating module.
`default_nettype none

module shp_line_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [DATA_W-1:0] rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // forward the word being written when a read hits it
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> src/shp_kernel.sv
// Sharpening kernel: center tap times pixel plus neighbor tap times the sum of
// the eight neighbors, per channel, clipped to 0..255. Depends on shp_pkg.
`default_nettype none

module shp_kernel import shp_pkg::*; (
  input  pix_t  win [WIN_TAPS],
  input  coef_t coef,
  output pix_t  result
);

  localparam int NSUM_W  = CH_W + 3;
  localparam int PC_W    = COEF_W + CH_W;
  localparam int PN_W    = COEF_W + NSUM_W + 1;
  localparam int SUM_W   = PN_W + 1;
  localparam int SHIFT_W = SUM_W - 1 - COEF_FRAC_BITS;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [NSUM_W-1:0]        nsum;
    logic [CH_W-1:0]          ctr;
    logic signed [PC_W-1:0]   prod_c;
    logic signed [PN_W-1:0]   prod_n;
    logic signed [SUM_W-1:0]  sum;
    logic [SHIFT_W-1:0]       shifted;
    logic [CH_W-1:0]          res;

    always_comb begin
      nsum = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
        if (k != CENTER_TAP) begin
          nsum = nsum + NSUM_W'(win[k][ch*CH_W +: CH_W]);
        end
      end
    end

    assign ctr     = win[CENTER_TAP][ch*CH_W +: CH_W];
    assign prod_c  = coef.center * $signed({1'b0, ctr});
    assign prod_n  = coef.neighbor * $signed({1'b0, nsum});
    assign sum     = SUM_W'(prod_c) + SUM_W'(prod_n);
    assign shifted = sum[SUM_W-2:COEF_FRAC_BITS];

    always_comb begin
      if (sum[SUM_W-1]) begin
        res = '0;
      end else if (shifted > SHIFT_W'(SAT_MAX)) begin
        res = CH_W'(SAT_MAX);
      end else begin
        res = shifted[CH_W-1:0];
      end
    end

    assign result[ch*CH_W +: CH_W] = res;
  end

endmodule

`default_nettype wire

>>> src/shp_checker.sv
// Port checker for sharpen_3x3_rgb_stream, bound to the top level.
// Depends on shp_pkg for the stream width.
`default_nettype none

module shp_checker import shp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // reset empties the input register
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // an empty result register never holds back the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

bind sharpen_3x3_rgb_stream shp_checker u_shp_checker (.*);

`default_nettype wire
